### design/d2g_pkg.sv
// shared widths and controller/datapath command and status types
package d2g_pkg;

  localparam int DAY_WIDTH = 22;
  localparam int YEAR_W    = DAY_WIDTH - 8;
  localparam int DBY_W     = DAY_WIDTH + 1;

  typedef struct packed {
    logic load;
    logic est;
    logic prep;
    logic use_year;
    logic test;
    logic fin;
  } d2g_cmd_t;

  typedef struct packed {
    logic fits;
  } d2g_status_t;

endpackage

### design/d2g_dp.sv
// datapath: year estimate, year correction, leap test, month lookup, weekday
module d2g_dp import d2g_pkg::*; (
  input  logic                 clk,
  input  d2g_cmd_t             cmd,
  output d2g_status_t          status,
  input  logic [DAY_WIDTH-1:0] day_count,
  output logic [13:0]          year,
  output logic [8:0]           day_of_year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month,
  output logic [2:0]           weekday
);

  // reciprocal constants for exact division by 365, 100 and 7
  localparam int K365 = DAY_WIDTH + 9;
  localparam logic [DAY_WIDTH:0] M365 =
    (DAY_WIDTH+1)'(((64'd1 << K365) + 64'd364) / 64'd365);
  localparam int K100 = YEAR_W + 7;
  localparam logic [YEAR_W:0] M100 =
    (YEAR_W+1)'(((64'd1 << K100) + 64'd99) / 64'd100);
  localparam int K7 = DAY_WIDTH + 4;
  localparam logic [DAY_WIDTH+1:0] M7 =
    (DAY_WIDTH+2)'(((64'd1 << K7) + 64'd6) / 64'd7);
  localparam int Q100_W = YEAR_W - 6;
  localparam int Q7_W   = DAY_WIDTH - 1;

  logic [DAY_WIDTH-1:0] days;
  logic [YEAR_W-1:0]    yr;
  logic [Q7_W-1:0]      q7;
  logic [DBY_W-1:0]     y365;
  logic [Q100_W-1:0]    q100;
  logic [8:0]           yday;

  logic [2*DAY_WIDTH:0]   prod365;
  logic [DAY_WIDTH:0]     days6;
  logic [2*DAY_WIDTH+1:0] prod7;
  logic [YEAR_W-1:0]      div_in;
  logic [2*YEAR_W:0]      prod100;
  logic [DBY_W-1:0]       days_ext;
  logic [DBY_W-1:0]       dby;
  logic [DBY_W-1:0]       yr_ext;
  logic [DBY_W-1:0]       q100_ext;
  logic                   fits;
  logic [DAY_WIDTH:0]     rem7;
  logic [YEAR_W-1:0]      hund;
  logic                   leap;
  logic [3:0]             mon_c;
  logic [8:0]             ms;

  function automatic logic [8:0] month_start(input logic lp, input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = lp ? 9'd60  : 9'd59;
      4'd3:    v = lp ? 9'd91  : 9'd90;
      4'd4:    v = lp ? 9'd121 : 9'd120;
      4'd5:    v = lp ? 9'd152 : 9'd151;
      4'd6:    v = lp ? 9'd182 : 9'd181;
      4'd7:    v = lp ? 9'd213 : 9'd212;
      4'd8:    v = lp ? 9'd244 : 9'd243;
      4'd9:    v = lp ? 9'd274 : 9'd273;
      4'd10:   v = lp ? 9'd305 : 9'd304;
      4'd11:   v = lp ? 9'd335 : 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  always_comb begin
    prod365 = (2*DAY_WIDTH+1)'(days) * (2*DAY_WIDTH+1)'(M365);
    days6   = (DAY_WIDTH+1)'(days) + (DAY_WIDTH+1)'(6);
    prod7   = (2*DAY_WIDTH+2)'(days6) * (2*DAY_WIDTH+2)'(M7);
    div_in  = cmd.use_year ? yr : yr - YEAR_W'(1);
    prod100 = (2*YEAR_W+1)'(div_in) * (2*YEAR_W+1)'(M100);

    // days before january 1 of yr, valid for yr above zero
    days_ext = DBY_W'(days);
    yr_ext   = DBY_W'(yr);
    q100_ext = DBY_W'(q100);
    dby      = y365 + ((yr_ext + DBY_W'(3)) >> 2) - q100_ext + (q100_ext >> 2);
    fits     = (yr == '0) || (days_ext >= dby);
    status.fits = fits;

    rem7 = days6 - (DAY_WIDTH+1)'(q7) * (DAY_WIDTH+1)'(7);
    hund = YEAR_W'(q100) * YEAR_W'(100);
    leap = (yr[1:0] == 2'b00 && yr != hund) || (yr == hund && q100[1:0] == 2'b00);

    mon_c = '0;
    for (int m = 1; m < 12; m++) begin
      if (yday >= month_start(leap, 4'(m))) begin
        mon_c = mon_c + 4'd1;
      end
    end
    ms = month_start(leap, mon_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      days <= day_count;
    end
    if (cmd.est) begin
      yr <= prod365[K365 +: YEAR_W];
      q7 <= prod7[K7 +: Q7_W];
    end
    if (cmd.prep) begin
      y365 <= yr_ext * DBY_W'(365);
      q100 <= prod100[K100 +: Q100_W];
    end
    if (cmd.test) begin
      if (fits) begin
        yday <= 9'(days_ext - ((yr == '0) ? '0 : dby));
      end else begin
        yr <= yr - YEAR_W'(1);
      end
    end
    if (cmd.fin) begin
      year         <= 14'(yr);
      day_of_year  <= yday;
      month        <= mon_c;
      day_of_month <= 5'(yday - ms + 9'd1);
      weekday      <= rem7[2:0];
    end
  end

endmodule

### design/d2g_ctrl.sv
// controller: sequences estimate, year correction loop, leap test and output
module d2g_ctrl import d2g_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  d2g_status_t status,
  output d2g_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EST,
    S_PREP,
    S_TEST,
    S_LEAP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EST;
        end
      end
      S_EST: begin
        cmd.est    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.test   = 1'b1;
        state_next = status.fits ? S_LEAP : S_PREP;
      end
      S_LEAP: begin
        cmd.prep     = 1'b1;
        cmd.use_year = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end

endmodule

### design/days_to_gregorian_date.sv
// top level: day count to proleptic gregorian calendar date
//
// usage
//   a beat enters when start is high and busy is low; day_count is sampled
//   at that edge. one result beat follows: done is high for exactly one
//   cycle with year, day_of_year, month, day_of_month and weekday valid in
//   that cycle. the receiver cannot stall, so the result must be taken then.
// sequence
//   the year estimate day_count/365 is lowered one year per pass of the
//   correction loop; each test has a prep step (one multiply by the
//   reciprocal of 100) and then the day-count compare. with k tests (1 to
//   9 over the full input range) the states run est, k passes of prep and
//   test, leap and fin; done rises as fin ends. no beat enters while busy,
//   which is low again in the cycle done is high, so a new beat can enter then.
// reset
//   rst is synchronous and active high; it returns the controller to idle
//   and clears done. the result registers are not reset.
module days_to_gregorian_date import d2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [DAY_WIDTH-1:0] day_count,
  output logic                 done,
  output logic [13:0]          year,
  output logic [8:0]           day_of_year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month,
  output logic [2:0]           weekday
);

  d2g_cmd_t    cmd;
  d2g_status_t status;

  d2g_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  d2g_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .day_count    (day_count),
    .year         (year),
    .day_of_year  (day_of_year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

endmodule

### sim/d2g_date_checker.sv
// checker: predicts the calendar date of each accepted beat and compares results
module d2g_date_checker import d2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [DAY_WIDTH-1:0] day_count,
  input  logic                 done,
  input  logic [13:0]          year,
  input  logic [8:0]           day_of_year,
  input  logic [3:0]           month,
  input  logic [4:0]           day_of_month,
  input  logic [2:0]           weekday,
  output int                   fails,
  output int                   pending,
  output int                   checked
);

  typedef struct {
    logic [13:0] year;
    logic [8:0]  yday;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
  } civil_date_t;

  civil_date_t expected_dates[$];

  function automatic bit is_leap(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days from 0000-01-01 to january 1 of year y
  function automatic longint days_before_year(longint y);
    if (y == 0) begin
      return 0;
    end
    return 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
  endfunction

  function automatic int month_first_day(int m, bit leap);
    int base;
    case (m)
      0:  base = 0;
      1:  base = 31;
      2:  base = 59;
      3:  base = 90;
      4:  base = 120;
      5:  base = 151;
      6:  base = 181;
      7:  base = 212;
      8:  base = 243;
      9:  base = 273;
      10: base = 304;
      default: base = 334;
    endcase
    return base + ((leap && m >= 2) ? 1 : 0);
  endfunction

  function automatic civil_date_t civil_from_days(logic [DAY_WIDTH-1:0] days);
    longint d;
    longint y;
    longint yd;
    int m;
    bit leap;
    civil_date_t r;
    d = longint'(days);
    y = d / 365;
    while (y > 0 && d < days_before_year(y)) begin
      y--;
    end
    yd = d - days_before_year(y);
    leap = is_leap(y);
    m = 11;
    while (m > 0 && yd < month_first_day(m, leap)) begin
      m--;
    end
    r.year = y[13:0];
    r.yday = yd[8:0];
    r.month = m[3:0];
    r.mday = 5'(yd - month_first_day(m, leap) + 1);
    r.wday = 3'((d + 6) % 7);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    civil_date_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_dates.size() == 0) begin
          fails++;
          $display("%0t: result beat with no date expected, got year %0d", $time, year);
        end else begin
          want = expected_dates.pop_front();
          checked++;
          check_field("year", 32'(want.year), 32'(year));
          check_field("day_of_year", 32'(want.yday), 32'(day_of_year));
          check_field("month", 32'(want.month), 32'(month));
          check_field("day_of_month", 32'(want.mday), 32'(day_of_month));
          check_field("weekday", 32'(want.wday), 32'(weekday));
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(civil_from_days(day_count));
      end
      pending = expected_dates.size();
    end
  end

endmodule

### sim/tb_top.sv
// testbench top: drives day counts into the date converter and gives the verdict
module tb_top;
  import d2g_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 750;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [DAY_WIDTH-1:0] day_count;
  logic                 done;
  logic [13:0]          year;
  logic [8:0]           day_of_year;
  logic [3:0]           month;
  logic [4:0]           day_of_month;
  logic [2:0]           weekday;
  int                   fails;
  int                   pending;
  int                   checked;
  int                   cycles;
  int                   sent;
  bit                   bursting;

  days_to_gregorian_date dut (.*);

  d2g_date_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still expected", cycles, pending);
      $display("** days_to_gregorian_date: FAILED **");
      $finish;
    end
  end

  task automatic send_day(logic [DAY_WIDTH-1:0] days, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      day_count <= DAY_WIDTH'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    day_count <= days;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int roll;
    if (bursting) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(60, 15);
  endfunction

  initial begin
    int unsigned corner_days[] = '{
      0, 1, 58, 59, 60, 365, 366,         // year zero is leap
      36524, 36525,                       // end of year 99, start of year 100
      146096, 146097,                     // end of year 399, start of year 400
      694019, 694020,                     // 1900 is not leap: feb 28, mar 1
      730485, 730544, 730850, 730851,     // 2000: jan 1, feb 29, dec 31, 2001
      2097151, 2097152, 1398101, 2796202, // bit patterns
      4194302, 4194303                    // top of the input range
    };
    logic [DAY_WIDTH-1:0] days;
    rst = 1'b1;
    start = 1'b0;
    day_count = '0;
    sent = 0;
    bursting = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (corner_days[i]) begin
      send_day(DAY_WIDTH'(corner_days[i]), (i % 3 == 0) ? 0 : $urandom_range(2));
    end
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) begin
        bursting = ($urandom_range(2) == 0);
      end
      if (n == RANDOM_BEATS / 2) begin
        drain();
      end
      case ($urandom_range(9))
        0, 1:    days = DAY_WIDTH'($urandom_range(2000));
        2:       days = DAY_WIDTH'($urandom_range(4194303, 4100000));
        default: days = DAY_WIDTH'($urandom_range(4194303));
      endcase
      send_day(days, pick_gap());
    end

    drain();
    repeat (40) @(negedge clk);

    $display("%0d day counts sent, %0d dates checked, corners plus random days over", sent,
             checked);
    $display("the full 22-bit range, with bursts, idle gaps and drain pauses");
    if (fails == 0) begin
      $display("** days_to_gregorian_date: PASSED **");
    end else begin
      $display("** days_to_gregorian_date: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/d2g_pkg.sv
design/d2g_dp.sv
design/d2g_ctrl.sv
design/days_to_gregorian_date.sv
sim/d2g_date_checker.sv
sim/tb_top.sv
